### hw/rtl/box_mesh_face_corner_indexer_top_macros.svh
// Assertion helpers for the face corner indexer.
`ifndef BOX_MESH_FACE_CORNER_INDEXER_TOP_MACROS_SVH
`define BOX_MESH_FACE_CORNER_INDEXER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BMFCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BMFCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bmfci_pkg.sv
`default_nettype none
package bmfci_pkg;

    localparam int FACE_W     = 23;
    localparam int DIV_W      = 10;
    localparam int CORNER_W   = 23;
    localparam int OFFSET_W   = 25;
    localparam int REM_W      = 20;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int Q_W        = 10;
    localparam int DIV_STAGES = 5;

    localparam logic [DIV_W-1:0] MAX_DIVISIONS = 10'd1023;
    localparam logic [DIV_W-1:0] DIV_RESET     = 10'd3;

    typedef enum logic [1:0] {
        REG_DIV_X = 2'd0,
        REG_DIV_Y = 2'd1,
        REG_DIV_Z = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        SIDE_XN = 3'd0,
        SIDE_XP = 3'd1,
        SIDE_YN = 3'd2,
        SIDE_YP = 3'd3,
        SIDE_ZN = 3'd4,
        SIDE_ZP = 3'd5
    } side_t;

    typedef struct packed {
        logic [DIV_W-1:0] dx;
        logic [DIV_W-1:0] dy;
        logic [DIV_W-1:0] dz;
    } cfg_t;

    typedef struct packed {
        logic [CORNER_W-1:0] far_base;
        logic [19:0]         ring_base;
        logic [DIV_W-1:0]    dz_m1;
        logic [11:0]         ring2;
        logic [10:0]         dz_p1;
    } derived_t;

    typedef struct packed {
        logic              ok;
        side_t             side;
        logic [REM_W-1:0]  rem;
        logic [DIV_W-1:0]  d;
        logic [Q_W-1:0]    q;
        logic [FACE_W-1:0] f;
    } div_word_t;

    typedef struct packed {
        logic [DIV_W-1:0] x;
        logic [DIV_W-1:0] y;
        logic [DIV_W-1:0] z;
        logic [20:0]      p1;
        logic [21:0]      p2;
    } corner_t;

    typedef struct packed {
        logic              ok;
        logic [FACE_W-1:0] f;
        corner_t [3:0]     c;
    } vert_word_t;

    typedef struct packed {
        logic                face_valid;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_d;
        logic [OFFSET_W-1:0] list_offset;
    } out_word_t;

    function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] v);
        logic [DIV_W-1:0] r;
        r = v;
        if (v > MAX_DIVISIONS)
            r = MAX_DIVISIONS;
        return r;
    endfunction

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic [DIV_W-1:0] d,
                                                input logic [3:0] sh);
        logic [REM_W-1:0] dd;
        logic [REM_W:0]   r;
        dd = REM_W'(d) << sh;
        if (rem >= dd)
            r = {1'b1, rem - dd};
        else
            r = {1'b0, rem};
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/bmfci_in_if.sv
`default_nettype none
interface bmfci_in_if;
    logic                          valid;
    logic                          ready;
    logic [bmfci_pkg::FACE_W-1:0]  face_number;

    modport source (output valid, output face_number, input ready);
    modport sink   (input valid, input face_number, output ready);
endinterface
`default_nettype wire

### hw/rtl/bmfci_out_if.sv
`default_nettype none
interface bmfci_out_if;
    logic                           valid;
    logic                           ready;
    logic                           face_valid;
    logic [bmfci_pkg::CORNER_W-1:0] corner_a;
    logic [bmfci_pkg::CORNER_W-1:0] corner_b;
    logic [bmfci_pkg::CORNER_W-1:0] corner_c;
    logic [bmfci_pkg::CORNER_W-1:0] corner_d;
    logic [bmfci_pkg::OFFSET_W-1:0] list_offset;

    modport source (output valid, output face_valid, output corner_a, output corner_b,
                    output corner_c, output corner_d, output list_offset, input ready);
    modport sink   (input valid, input face_valid, input corner_a, input corner_b,
                    input corner_c, input corner_d, input list_offset, output ready);
endinterface
`default_nettype wire

### hw/rtl/bmfci_cfg.sv
`default_nettype none
module bmfci_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bmfci_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bmfci_pkg::DATA_W-1:0]   pwdata,
    output logic      [bmfci_pkg::DATA_W-1:0]   prdata,
    output logic                                pready,
    output bmfci_pkg::cfg_t                     cfg,
    output bmfci_pkg::derived_t                 drv
);

    bmfci_pkg::cfg_t     cfg_reg;
    bmfci_pkg::cfg_t     cfg_next;
    logic                wr;
    logic [22:0]         pa_reg;
    logic [19:0]         pb_reg;
    logic [21:0]         pc_reg;
    logic [19:0]         pd_reg;
    logic [11:0]         sum2;
    bmfci_pkg::derived_t drv_reg;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (bmfci_pkg::reg_idx_t'(paddr[3:2]))
                bmfci_pkg::REG_DIV_X: cfg_next.dx = bmfci_pkg::clamp_div(pwdata[9:0]);
                bmfci_pkg::REG_DIV_Y: cfg_next.dy = bmfci_pkg::clamp_div(pwdata[9:0]);
                bmfci_pkg::REG_DIV_Z: cfg_next.dz = bmfci_pkg::clamp_div(pwdata[9:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (bmfci_pkg::reg_idx_t'(paddr[3:2]))
            bmfci_pkg::REG_DIV_X: prdata = {22'd0, cfg_reg.dx};
            bmfci_pkg::REG_DIV_Y: prdata = {22'd0, cfg_reg.dy};
            bmfci_pkg::REG_DIV_Z: prdata = {22'd0, cfg_reg.dz};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dx <= bmfci_pkg::DIV_RESET;
            cfg_reg.dy <= bmfci_pkg::DIV_RESET;
            cfg_reg.dz <= bmfci_pkg::DIV_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign sum2 = {11'(cfg_reg.dx) + 11'(cfg_reg.dy), 1'b0};

    // derived geometry constants, registered from the settings
    always_ff @(posedge clk)
    begin
        pa_reg <= 23'(sum2) * 23'(11'(cfg_reg.dz) + 11'd1);
        pb_reg <= (20'(cfg_reg.dx) - 20'd1) * (20'(cfg_reg.dy) - 20'd1);
        pc_reg <= 22'(11'(cfg_reg.dy) + 11'd1) * 22'(11'(cfg_reg.dz) + 11'd1);
        pd_reg <= (20'(cfg_reg.dy) - 20'd1) * (20'(cfg_reg.dz) - 20'd1);
        drv_reg.far_base  <= pa_reg + 23'({pb_reg, 1'b0}) - 23'(pc_reg);
        drv_reg.ring_base <= pd_reg;
        drv_reg.dz_m1     <= cfg_reg.dz - 10'd1;
        drv_reg.ring2     <= {11'(cfg_reg.dy) + 11'(cfg_reg.dz), 1'b0};
        drv_reg.dz_p1     <= 11'(cfg_reg.dz) + 11'd1;
    end

    assign cfg = cfg_reg;
    assign drv = drv_reg;

endmodule
`default_nettype wire

### hw/rtl/bmfci_front.sv
`default_nettype none
module bmfci_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bmfci_pkg::cfg_t               cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bmfci_pkg::FACE_W-1:0]  in_f,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bmfci_pkg::div_word_t               out_word
);

    logic [2:0]  v_reg;
    logic [3:0]  en;

    logic [22:0] f1_reg;
    logic [19:0] sx_reg, sy_reg, sz_reg;
    logic        zero1_reg;

    logic [22:0] f2_reg;
    logic [22:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, cnt_reg;
    logic        zero2_reg;

    bmfci_pkg::div_word_t w3_reg;
    bmfci_pkg::div_word_t w3_next;
    logic [22:0]          base;

    always_comb
    begin
        en[3] = out_ready;
        for (int k = 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f1_reg    <= in_f;
            sx_reg    <= 20'(cfg.dy) * 20'(cfg.dz);
            sy_reg    <= 20'(cfg.dx) * 20'(cfg.dz);
            sz_reg    <= 20'(cfg.dx) * 20'(cfg.dy);
            zero1_reg <= (cfg.dx == '0) || (cfg.dy == '0) || (cfg.dz == '0);
        end
        if (en[1])
        begin
            f2_reg    <= f1_reg;
            t1_reg    <= 23'(sx_reg);
            t2_reg    <= 23'({sx_reg, 1'b0});
            t3_reg    <= 23'({sx_reg, 1'b0}) + 23'(sy_reg);
            t4_reg    <= 23'({sx_reg, 1'b0}) + 23'({sy_reg, 1'b0});
            t5_reg    <= 23'({sx_reg, 1'b0}) + 23'({sy_reg, 1'b0}) + 23'(sz_reg);
            cnt_reg   <= 23'({sx_reg, 1'b0}) + 23'({sy_reg, 1'b0}) + 23'({sz_reg, 1'b0});
            zero2_reg <= zero1_reg;
        end
        if (en[2])
            w3_reg <= w3_next;
    end

    always_comb
    begin
        w3_next   = '0;
        w3_next.f = f2_reg;
        w3_next.ok = !zero2_reg && (f2_reg < cnt_reg);
        if (f2_reg < t1_reg)
        begin
            w3_next.side = bmfci_pkg::SIDE_XN;
            base = '0;
        end
        else if (f2_reg < t2_reg)
        begin
            w3_next.side = bmfci_pkg::SIDE_XP;
            base = t1_reg;
        end
        else if (f2_reg < t3_reg)
        begin
            w3_next.side = bmfci_pkg::SIDE_YN;
            base = t2_reg;
        end
        else if (f2_reg < t4_reg)
        begin
            w3_next.side = bmfci_pkg::SIDE_YP;
            base = t3_reg;
        end
        else if (f2_reg < t5_reg)
        begin
            w3_next.side = bmfci_pkg::SIDE_ZN;
            base = t4_reg;
        end
        else
        begin
            w3_next.side = bmfci_pkg::SIDE_ZP;
            base = t5_reg;
        end
        w3_next.rem = 20'(f2_reg - base);
        if (w3_next.side == bmfci_pkg::SIDE_ZN || w3_next.side == bmfci_pkg::SIDE_ZP)
            w3_next.d = cfg.dy;
        else
            w3_next.d = cfg.dz;
    end

    assign out_valid = v_reg[2];
    assign out_word  = w3_reg;

endmodule
`default_nettype wire

### hw/rtl/bmfci_div.sv
`default_nettype none
module bmfci_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire bmfci_pkg::div_word_t in_word,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bmfci_pkg::div_word_t      out_word
);

    logic [bmfci_pkg::DIV_STAGES-1:0] v_reg;
    logic [bmfci_pkg::DIV_STAGES:0]   en;
    bmfci_pkg::div_word_t w_reg  [bmfci_pkg::DIV_STAGES];
    bmfci_pkg::div_word_t w_next [bmfci_pkg::DIV_STAGES];

    always_comb
    begin
        en[bmfci_pkg::DIV_STAGES] = out_ready;
        for (int k = bmfci_pkg::DIV_STAGES - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready = en[0];

    // two quotient bits per stage, most significant first
    always_comb
    begin
        logic [20:0]          s_hi;
        logic [20:0]          s_lo;
        bmfci_pkg::div_word_t src;
        for (int k = 0; k < bmfci_pkg::DIV_STAGES; k++)
        begin
            src  = (k == 0) ? in_word : w_reg[(k == 0) ? 0 : k - 1];
            s_hi = bmfci_pkg::div_step(src.rem, src.d, 4'(9 - 2 * k));
            s_lo = bmfci_pkg::div_step(s_hi[19:0], src.d, 4'(8 - 2 * k));
            w_next[k]        = src;
            w_next[k].rem    = s_lo[19:0];
            w_next[k].q[9 - 2 * k] = s_hi[20];
            w_next[k].q[8 - 2 * k] = s_lo[20];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < bmfci_pkg::DIV_STAGES; k++)
                if (en[k])
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < bmfci_pkg::DIV_STAGES; k++)
            if (en[k])
                w_reg[k] <= w_next[k];
    end

    assign out_valid = v_reg[bmfci_pkg::DIV_STAGES-1];
    assign out_word  = w_reg[bmfci_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/bmfci_vert.sv
`default_nettype none
module bmfci_vert (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bmfci_pkg::cfg_t      cfg,
    input  wire bmfci_pkg::derived_t  drv,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire bmfci_pkg::div_word_t in_word,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bmfci_pkg::out_word_t      out_word
);

    logic [1:0]            v_reg;
    logic [2:0]            en;
    bmfci_pkg::vert_word_t w1_reg;
    bmfci_pkg::vert_word_t w1_next;
    bmfci_pkg::out_word_t  w2_reg;
    bmfci_pkg::out_word_t  w2_next;
    logic [22:0]           vi [4];

    always_comb
    begin
        en[2] = out_ready;
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign in_ready = en[0];

    always_comb
    begin
        logic                  swap;
        logic [3:0]            oa;
        logic [3:0]            ob;
        logic [9:0]            i;
        logic [9:0]            j;
        logic [9:0]            ci;
        logic [9:0]            cj;
        w1_next    = '0;
        w1_next.ok = in_word.ok;
        w1_next.f  = in_word.f;
        i = in_word.q;
        j = in_word.rem[9:0];
        swap = (in_word.side == bmfci_pkg::SIDE_XP) || (in_word.side == bmfci_pkg::SIDE_YN)
            || (in_word.side == bmfci_pkg::SIDE_ZP);
        oa = swap ? 4'b0110 : 4'b1100;
        ob = swap ? 4'b1100 : 4'b0110;
        for (int k = 0; k < 4; k++)
        begin
            ci = i + 10'(oa[k]);
            cj = j + 10'(ob[k]);
            case (in_word.side)
                bmfci_pkg::SIDE_XN:
                begin
                    w1_next.c[k].x = '0;  w1_next.c[k].y = ci;     w1_next.c[k].z = cj;
                end
                bmfci_pkg::SIDE_XP:
                begin
                    w1_next.c[k].x = cfg.dx; w1_next.c[k].y = ci;  w1_next.c[k].z = cj;
                end
                bmfci_pkg::SIDE_YN:
                begin
                    w1_next.c[k].x = ci;  w1_next.c[k].y = '0;     w1_next.c[k].z = cj;
                end
                bmfci_pkg::SIDE_YP:
                begin
                    w1_next.c[k].x = ci;  w1_next.c[k].y = cfg.dy; w1_next.c[k].z = cj;
                end
                bmfci_pkg::SIDE_ZN:
                begin
                    w1_next.c[k].x = ci;  w1_next.c[k].y = cj;     w1_next.c[k].z = '0;
                end
                default:
                begin
                    w1_next.c[k].x = ci;  w1_next.c[k].y = cj;     w1_next.c[k].z = cfg.dz;
                end
            endcase
            w1_next.c[k].p1 = 21'(w1_next.c[k].y) * 21'(drv.dz_p1);
            w1_next.c[k].p2 = 22'(w1_next.c[k].x) * 22'(drv.ring2);
        end
    end

    always_comb
    begin
        logic [22:0] base;
        logic [22:0] y2;
        for (int k = 0; k < 4; k++)
        begin
            base = 23'(drv.ring_base) + 23'(w1_reg.c[k].p2);
            y2   = 23'({w1_reg.c[k].y, 1'b0});
            if (w1_reg.c[k].x == '0)
                vi[k] = 23'(w1_reg.c[k].p1) + 23'(w1_reg.c[k].z);
            else if (w1_reg.c[k].x == cfg.dx)
                vi[k] = drv.far_base + 23'(w1_reg.c[k].p1) + 23'(w1_reg.c[k].z);
            else if (w1_reg.c[k].y == '0)
                vi[k] = base + 23'(w1_reg.c[k].z);
            else if (w1_reg.c[k].y == cfg.dy)
                vi[k] = base + 23'(drv.dz_m1) + y2 + 23'(w1_reg.c[k].z);
            else
                vi[k] = base + 23'(drv.dz_m1) + y2 + 23'(w1_reg.c[k].z != '0);
        end
        w2_next = '0;
        if (w1_reg.ok)
        begin
            w2_next.face_valid  = 1'b1;
            w2_next.corner_a    = vi[0];
            w2_next.corner_b    = vi[1];
            w2_next.corner_c    = vi[2];
            w2_next.corner_d    = vi[3];
            w2_next.list_offset = {w1_reg.f, 2'b00} + 25'd4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) w1_reg <= w1_next;
        if (en[1]) w2_reg <= w2_next;
    end

    assign out_valid = v_reg[1];
    assign out_word  = w2_reg;

endmodule
`default_nettype wire

### hw/rtl/box_mesh_face_corner_indexer_top.sv
// Box mesh face corner indexer.
// in_ch carries one face number per word; out_ch returns one word per face:
// face_valid, the four corner vertex indices in winding order and the
// vertex-list offset. A face number at or past the face count, or any zero
// division count, returns face_valid low with all other fields zero.
// Division counts are set through the APB port (x at 0x0, y at 0x4, z at
// 0x8) and must only change while no face is in flight; internal geometry
// constants are registered from the division counts.
// A face passes through side decode, the radix-4 restoring divider and
// index arithmetic, each a chain of registered stages. One face is accepted
// every cycle while the receiver does not stall.
// Each stage holds its word while the stage after it is full and held, so a stalled
// receiver backs up the pipeline one stage at a time; in_ch.ready drops only
// once every stage is occupied. Nothing is lost or repeated.
// Reset clears all pipeline valid bits and sets each division count to 3.
`default_nettype none
`include "box_mesh_face_corner_indexer_top_macros.svh"
module box_mesh_face_corner_indexer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bmfci_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bmfci_pkg::DATA_W-1:0]  pwdata,
    output logic      [bmfci_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    bmfci_in_if.sink                           in_ch,
    bmfci_out_if.source                        out_ch
);

    bmfci_pkg::cfg_t      cfg;
    bmfci_pkg::derived_t  drv;
    logic                 fd_valid, fd_ready;
    bmfci_pkg::div_word_t fd_word;
    logic                 dv_valid, dv_ready;
    bmfci_pkg::div_word_t dv_word;
    bmfci_pkg::out_word_t res;

    bmfci_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cfg(cfg), .drv(drv)
    );

    bmfci_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_f(in_ch.face_number),
        .out_valid(fd_valid), .out_ready(fd_ready), .out_word(fd_word)
    );

    bmfci_div u_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fd_valid), .in_ready(fd_ready), .in_word(fd_word),
        .out_valid(dv_valid), .out_ready(dv_ready), .out_word(dv_word)
    );

    bmfci_vert u_vert (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .drv(drv),
        .in_valid(dv_valid), .in_ready(dv_ready), .in_word(dv_word),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(res)
    );

    assign out_ch.face_valid  = res.face_valid;
    assign out_ch.corner_a    = res.corner_a;
    assign out_ch.corner_b    = res.corner_b;
    assign out_ch.corner_c    = res.corner_c;
    assign out_ch.corner_d    = res.corner_d;
    assign out_ch.list_offset = res.list_offset;

    `BMFCI_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_ch.valid && !out_ch.face_valid, out_ch.corner_a == '0 && out_ch.corner_d == '0 && out_ch.list_offset == '0, "invalid face carries nonzero fields")
    `BMFCI_ASSERT_NOW(a_offset_form, clk, rst_n, out_ch.valid && out_ch.face_valid, out_ch.list_offset[1:0] == 2'b00 && out_ch.list_offset != '0, "list offset malformed")
    `BMFCI_ASSERT_NOW(a_full_stall, clk, rst_n, !in_ch.ready, out_ch.valid && !out_ch.ready, "input blocked without output stall")

endmodule
`default_nettype wire

### test/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    class face_scoreboard;
        longint unsigned      dx, dy, dz;
        bmfci_pkg::out_word_t pending[$];
        int                   errors;
        int                   checked;

        function new();
            dx = 3;
            dy = 3;
            dz = 3;
        endfunction

        function longint unsigned face_count();
            return 2 * (dy * dz + dx * dz + dx * dy);
        endfunction

        function longint unsigned vertex_of(longint unsigned x, longint unsigned y,
                                            longint unsigned z);
            longint unsigned slab, total, base;
            slab  = (dy + 1) * (dz + 1);
            total = (dx + dy) * 2 * (dz + 1) + ((dx + 1) * (dy + 1) - (dx + dy) * 2) * 2;
            if (x == 0)
                return y * (dz + 1) + z;
            if (x == dx)
                return total - slab + y * (dz + 1) + z;
            base = (dy - 1) * (dz - 1) + (dy + dz) * 2 * x;
            if (y == 0)
                return base + z;
            if (y == dy)
                return base + (dz - 1) + 2 * y + z;
            return base + (dz - 1) + 2 * y + ((z != 0) ? 1 : 0);
        endfunction

        function bmfci_pkg::out_word_t corners_of(logic [bmfci_pkg::FACE_W-1:0] face);
            bmfci_pkg::out_word_t w;
            longint unsigned      r, i, j, sx, sy, sz;
            longint unsigned      v[4];
            bit                   plus;
            w  = '0;
            sx = dy * dz;
            sy = dx * dz;
            sz = dx * dy;
            r  = face;
            if (dx == 0 || dy == 0 || dz == 0 || r >= face_count())
                return w;
            if (r < 2 * sx) begin
                plus = r >= sx;
                if (plus)
                    r -= sx;
                i = r / dz;
                j = r % dz;
                if (!plus) begin
                    v[0] = vertex_of(0, i, j);
                    v[1] = vertex_of(0, i, j + 1);
                    v[2] = vertex_of(0, i + 1, j + 1);
                    v[3] = vertex_of(0, i + 1, j);
                end
                else begin
                    v[0] = vertex_of(dx, i, j);
                    v[1] = vertex_of(dx, i + 1, j);
                    v[2] = vertex_of(dx, i + 1, j + 1);
                    v[3] = vertex_of(dx, i, j + 1);
                end
            end
            else if (r < 2 * (sx + sy)) begin
                r -= 2 * sx;
                plus = r >= sy;
                if (plus)
                    r -= sy;
                i = r / dz;
                j = r % dz;
                if (!plus) begin
                    v[0] = vertex_of(i, 0, j);
                    v[1] = vertex_of(i + 1, 0, j);
                    v[2] = vertex_of(i + 1, 0, j + 1);
                    v[3] = vertex_of(i, 0, j + 1);
                end
                else begin
                    v[0] = vertex_of(i, dy, j);
                    v[1] = vertex_of(i, dy, j + 1);
                    v[2] = vertex_of(i + 1, dy, j + 1);
                    v[3] = vertex_of(i + 1, dy, j);
                end
            end
            else begin
                r -= 2 * (sx + sy);
                plus = r >= sz;
                if (plus)
                    r -= sz;
                i = r / dy;
                j = r % dy;
                if (!plus) begin
                    v[0] = vertex_of(i, j, 0);
                    v[1] = vertex_of(i, j + 1, 0);
                    v[2] = vertex_of(i + 1, j + 1, 0);
                    v[3] = vertex_of(i + 1, j, 0);
                end
                else begin
                    v[0] = vertex_of(i, j, dz);
                    v[1] = vertex_of(i + 1, j, dz);
                    v[2] = vertex_of(i + 1, j + 1, dz);
                    v[3] = vertex_of(i, j + 1, dz);
                end
            end
            w.face_valid  = 1'b1;
            w.corner_a    = v[0][bmfci_pkg::CORNER_W-1:0];
            w.corner_b    = v[1][bmfci_pkg::CORNER_W-1:0];
            w.corner_c    = v[2][bmfci_pkg::CORNER_W-1:0];
            w.corner_d    = v[3][bmfci_pkg::CORNER_W-1:0];
            w.list_offset = bmfci_pkg::OFFSET_W'(4 * longint'(face) + 4);
            return w;
        endfunction

        function void note_face(logic [bmfci_pkg::FACE_W-1:0] face);
            pending.push_back(corners_of(face));
        endfunction

        function void check_word(bmfci_pkg::out_word_t got);
            bmfci_pkg::out_word_t exp;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected output word");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.face_valid !== exp.face_valid) begin
                $error("face_valid exp %0d got %0d", exp.face_valid, got.face_valid);
                errors++;
            end
            if (got.corner_a !== exp.corner_a) begin
                $error("corner_a exp %0d got %0d", exp.corner_a, got.corner_a);
                errors++;
            end
            if (got.corner_b !== exp.corner_b) begin
                $error("corner_b exp %0d got %0d", exp.corner_b, got.corner_b);
                errors++;
            end
            if (got.corner_c !== exp.corner_c) begin
                $error("corner_c exp %0d got %0d", exp.corner_c, got.corner_c);
                errors++;
            end
            if (got.corner_d !== exp.corner_d) begin
                $error("corner_d exp %0d got %0d", exp.corner_d, got.corner_d);
                errors++;
            end
            if (got.list_offset !== exp.list_offset) begin
                $error("list_offset exp %0d got %0d", exp.list_offset, got.list_offset);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bmfci_pkg::ADDR_W-1:0]  paddr;
    logic [bmfci_pkg::DATA_W-1:0]  pwdata;
    logic [bmfci_pkg::DATA_W-1:0]  prdata;
    logic                          pready;

    bmfci_in_if  in_ch();
    bmfci_out_if out_ch();

    box_mesh_face_corner_indexer_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    face_scoreboard       faces = new();
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   cycles;
    int                   sent;
    logic                 out_fire;
    bmfci_pkg::out_word_t out_sample;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.face_number = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 17;
        recv_stall_pct = 76;
        cycles         = 0;
        sent           = 0;
        out_fire       = 1'b0;
        out_sample     = '0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("box_mesh_face_corner_indexer_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(negedge clk)
    begin
        out_fire               <= out_ch.valid && out_ch.ready;
        out_sample.face_valid  <= out_ch.face_valid;
        out_sample.corner_a    <= out_ch.corner_a;
        out_sample.corner_b    <= out_ch.corner_b;
        out_sample.corner_c    <= out_ch.corner_c;
        out_sample.corner_d    <= out_ch.corner_d;
        out_sample.list_offset <= out_ch.list_offset;
    end

    always @(posedge clk)
        if (rst_n && out_fire)
            faces.check_word(out_sample);

    task automatic write_reg(bmfci_pkg::reg_idx_t idx, logic [bmfci_pkg::DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bmfci_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bmfci_pkg::REG_DIV_X: faces.dx = value[bmfci_pkg::DIV_W-1:0];
            bmfci_pkg::REG_DIV_Y: faces.dy = value[bmfci_pkg::DIV_W-1:0];
            default:              faces.dz = value[bmfci_pkg::DIV_W-1:0];
        endcase
    endtask

    task automatic send_face(logic [bmfci_pkg::FACE_W-1:0] face);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.face_number <= face;
        do begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end while (!taken);
        faces.note_face(face);
        sent++;
        if (sent == 520) begin
            send_idle_pct  = 76;
            recv_stall_pct = 17;
        end
        else if (sent == 1040) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (faces.pending.size() != 0)
            @(posedge clk);
        repeat (14) @(posedge clk);
    endtask

    task automatic run_phase(int n);
        longint unsigned count;
        int              pick;
        count = faces.face_count();
        send_face('0);
        send_face(bmfci_pkg::FACE_W'(count - 1));
        send_face(bmfci_pkg::FACE_W'(count));
        send_face({bmfci_pkg::FACE_W{1'b1}});
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(9);
            if (pick < 8 && count > 0)
                send_face(bmfci_pkg::FACE_W'($urandom_range(int'(count - 1), 0)));
            else if (pick == 8)
                send_face(bmfci_pkg::FACE_W'(count + $urandom_range(15)));
            else
                send_face(bmfci_pkg::FACE_W'($urandom));
        end
        drain();
    endtask

    initial
    begin
        logic [bmfci_pkg::DATA_W-1:0] settings[9][3];
        settings = '{
            '{32'd1, 32'd1, 32'd1},
            '{32'd1023, 32'd1023, 32'd1023},
            '{32'd0, 32'd4, 32'd4},
            '{32'd5, 32'd0, 32'd2},
            '{32'd1023, 32'd1, 32'd1},
            '{32'd1, 32'd1023, 32'd2},
            '{32'd2, 32'd3, 32'd1023},
            '{32'hFFFF_FC06, 32'd5, 32'd0},
            '{32'd7, 32'd5, 32'd9}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int f = 0; f < 18; f++)
            send_face(bmfci_pkg::FACE_W'(f * 3));
        send_face(bmfci_pkg::FACE_W'(53));
        send_face(bmfci_pkg::FACE_W'(54));
        send_face(bmfci_pkg::FACE_W'(23'h400000));
        run_phase(150);
        foreach (settings[p]) begin
            write_reg(bmfci_pkg::REG_DIV_X, settings[p][0]);
            write_reg(bmfci_pkg::REG_DIV_Y, settings[p][1]);
            write_reg(bmfci_pkg::REG_DIV_Z, settings[p][2]);
            run_phase(150);
        end
        $display("faces sent %0d, words checked %0d, over 10 division settings",
                 sent, faces.checked);
        $display("covered all six sides, invalid and out-of-range faces, zero and max counts");
        if (faces.errors == 0 && faces.pending.size() == 0)
            $display("box_mesh_face_corner_indexer_top test passed");
        else
            $display("box_mesh_face_corner_indexer_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
